>>> src/pls_pkg.sv
// Package for the positional list store: sizes, action and status codes,
// the state encoding and the result record. No dependencies.
package pls_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_READ   = 3'd3,
        ACT_FIND   = 3'd4,
        ACT_DUMP   = 3'd5,
        ACT_CLEAR  = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_INS,
        S_INSV,
        S_REM,
        S_DUMP,
        S_FIND,
        S_FEND
    } t_state;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  element;
        logic [ADDR_W-1:0]         where;
        logic [CNT_W-1:0]          count;
        logic                      last;
    } t_result;

endpackage

>>> src/pls_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read
// port; read data holds while no read is issued. No dependencies.
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/positional_list_store_unit.sv
// Positional list store top level: sequencer around one element RAM.
// Depends on pls_pkg and pls_ram.
//
// A fixed-capacity ordered list of signed 32-bit values held in a single
// RAM with one write and one registered read port. Append, clear and bad
// requests are answered from the idle state, a read through S_READ. Insert
// (unless at the end of the list) and remove (unless of the last element)
// step through the moved elements, since every moved element passes once
// through the read port. Dump and find issue one read per cycle while the
// output is not stalled and produce results at up to one per cycle. Find
// holds each match until the next match or the list end, so that the last
// one carries last. A new transaction is taken once the previous one has
// issued its last result and the output register is free or being emptied.
module positional_list_store_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [2:0]                          i_action,
    input  logic signed [pls_pkg::DATA_W-1:0]   i_value,
    input  logic [pls_pkg::CNT_W-1:0]           i_position,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [2:0]                          o_status,
    output logic signed [pls_pkg::DATA_W-1:0]   o_element,
    output logic [pls_pkg::ADDR_W-1:0]          o_where,
    output logic [pls_pkg::CNT_W-1:0]           o_count,
    output logic                                o_last
);

    localparam int AW = pls_pkg::ADDR_W;
    localparam int CW = pls_pkg::CNT_W;
    localparam int DW = pls_pkg::DATA_W;

    pls_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_pos, n_pos;
    logic [DW-1:0]    r_val, n_val;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_pwhere, n_pwhere;
    logic             r_ovalid, n_ovalid;
    pls_pkg::t_result r_out, n_out;

    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    logic [DW-1:0]    wdata, rdata;
    logic             out_free, accept, at_end;
    pls_pkg::t_action act;

    pls_ram #(
        .WIDTH (DW),
        .DEPTH (pls_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = !((r_state == pls_pkg::S_IDLE) && out_free);
    assign accept   = i_valid && !o_stall;
    assign act      = pls_pkg::t_action'(i_action);
    assign at_end   = (CW'(r_idx) == (r_fill - CW'(1)));

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_val    = r_val;
        n_pend   = r_pend;
        n_pwhere = r_pwhere;
        n_ovalid = r_ovalid && i_stall;
        n_out    = r_out;
        we       = 1'b0;
        waddr    = r_idx;
        wdata    = rdata;
        re       = 1'b0;
        raddr    = r_idx;

        unique case (r_state)
            pls_pkg::S_IDLE: begin
                if (accept) begin
                    n_val    = i_value;
                    n_pos    = i_position[AW-1:0];
                    n_ovalid = 1'b1;
                    n_out    = '{pls_pkg::ST_OK, '0, '0, r_fill, 1'b1};
                    case (act)
                        pls_pkg::ACT_APPEND: begin
                            if (r_fill >= CW'(pls_pkg::CAPACITY)) begin
                                n_out.status = pls_pkg::ST_FULL;
                            end else begin
                                we          = 1'b1;
                                waddr       = r_fill[AW-1:0];
                                wdata       = i_value;
                                n_fill      = r_fill + CW'(1);
                                n_out.count = n_fill;
                            end
                        end
                        pls_pkg::ACT_INSERT: begin
                            if (i_position > r_fill) begin
                                n_out.status = pls_pkg::ST_BAD_POS;
                            end else if (r_fill >= CW'(pls_pkg::CAPACITY)) begin
                                n_out.status = pls_pkg::ST_FULL;
                            end else if (i_position == r_fill) begin
                                we          = 1'b1;
                                waddr       = i_position[AW-1:0];
                                wdata       = i_value;
                                n_fill      = r_fill + CW'(1);
                                n_out.count = n_fill;
                            end else begin
                                n_ovalid = r_ovalid && i_stall;
                                re       = 1'b1;
                                raddr    = r_fill[AW-1:0] - AW'(1);
                                n_idx    = r_fill[AW-1:0];
                                n_state  = pls_pkg::S_INS;
                            end
                        end
                        pls_pkg::ACT_REMOVE: begin
                            if (i_position >= r_fill) begin
                                n_out.status = pls_pkg::ST_BAD_POS;
                            end else if (i_position == r_fill - CW'(1)) begin
                                n_fill      = r_fill - CW'(1);
                                n_out.count = n_fill;
                            end else begin
                                n_ovalid = r_ovalid && i_stall;
                                re       = 1'b1;
                                raddr    = i_position[AW-1:0] + AW'(1);
                                n_idx    = i_position[AW-1:0];
                                n_state  = pls_pkg::S_REM;
                            end
                        end
                        pls_pkg::ACT_READ: begin
                            if (i_position >= r_fill) begin
                                n_out.status = pls_pkg::ST_BAD_POS;
                            end else begin
                                n_ovalid = r_ovalid && i_stall;
                                re       = 1'b1;
                                raddr    = i_position[AW-1:0];
                                n_state  = pls_pkg::S_READ;
                            end
                        end
                        pls_pkg::ACT_FIND: begin
                            if (r_fill == '0) begin
                                n_out.status = pls_pkg::ST_NOT_FOUND;
                            end else begin
                                n_ovalid = r_ovalid && i_stall;
                                re       = 1'b1;
                                raddr    = '0;
                                n_idx    = '0;
                                n_pend   = 1'b0;
                                n_state  = pls_pkg::S_FIND;
                            end
                        end
                        pls_pkg::ACT_DUMP: begin
                            if (r_fill == '0) begin
                                n_out.status = pls_pkg::ST_EMPTY;
                            end else begin
                                n_ovalid = r_ovalid && i_stall;
                                re       = 1'b1;
                                raddr    = '0;
                                n_idx    = '0;
                                n_state  = pls_pkg::S_DUMP;
                            end
                        end
                        pls_pkg::ACT_CLEAR: begin
                            n_fill      = '0;
                            n_out.count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pls_pkg::S_READ: begin
                n_ovalid = 1'b1;
                n_out    = '{pls_pkg::ST_OK, rdata, r_pos, r_fill, 1'b1};
                n_state  = pls_pkg::S_IDLE;
            end
            pls_pkg::S_INS: begin
                we    = 1'b1;
                waddr = r_idx;
                wdata = rdata;
                if (r_idx - AW'(1) == r_pos) begin
                    n_state = pls_pkg::S_INSV;
                end else begin
                    re    = 1'b1;
                    raddr = r_idx - AW'(2);
                    n_idx = r_idx - AW'(1);
                end
            end
            pls_pkg::S_INSV: begin
                we       = 1'b1;
                waddr    = r_pos;
                wdata    = r_val;
                n_fill   = r_fill + CW'(1);
                n_ovalid = 1'b1;
                n_out    = '{pls_pkg::ST_OK, '0, '0, n_fill, 1'b1};
                n_state  = pls_pkg::S_IDLE;
            end
            pls_pkg::S_REM: begin
                we    = 1'b1;
                waddr = r_idx;
                wdata = rdata;
                if (CW'(r_idx) + CW'(2) == r_fill) begin
                    n_fill   = r_fill - CW'(1);
                    n_ovalid = 1'b1;
                    n_out    = '{pls_pkg::ST_OK, '0, '0, n_fill, 1'b1};
                    n_state  = pls_pkg::S_IDLE;
                end else begin
                    re    = 1'b1;
                    raddr = r_idx + AW'(2);
                    n_idx = r_idx + AW'(1);
                end
            end
            pls_pkg::S_DUMP: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = '{pls_pkg::ST_OK, rdata, r_idx, r_fill, at_end};
                    if (at_end) begin
                        n_state = pls_pkg::S_IDLE;
                    end else begin
                        re    = 1'b1;
                        raddr = r_idx + AW'(1);
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            pls_pkg::S_FIND: begin
                if (out_free) begin
                    if (rdata == r_val) begin
                        if (r_pend) begin
                            n_ovalid = 1'b1;
                            n_out    = '{pls_pkg::ST_OK, '0, r_pwhere, r_fill, 1'b0};
                        end
                        n_pend   = 1'b1;
                        n_pwhere = r_idx;
                    end
                    if (at_end) begin
                        n_state = pls_pkg::S_FEND;
                    end else begin
                        re    = 1'b1;
                        raddr = r_idx + AW'(1);
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            pls_pkg::S_FEND: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    if (r_pend) begin
                        n_out = '{pls_pkg::ST_OK, '0, r_pwhere, r_fill, 1'b1};
                    end else begin
                        n_out = '{pls_pkg::ST_NOT_FOUND, '0, '0, r_fill, 1'b1};
                    end
                    n_pend  = 1'b0;
                    n_state = pls_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pls_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pls_pkg::S_IDLE;
            r_fill   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_pwhere <= n_pwhere;
        r_out    <= n_out;
    end

    assign o_valid   = r_ovalid;
    assign o_status  = r_out.status;
    assign o_element = r_out.element;
    assign o_where   = r_out.where;
    assign o_count   = r_out.count;
    assign o_last    = r_out.last;

endmodule
